>>> rtl/ivt_pkg.sv
// Package for the interval timer: field widths, request codes and the
// request and response payload structs. No dependencies.
`default_nettype none

package ivt_pkg;

  localparam int unsigned NS_W  = 57;
  localparam int unsigned DEC_W = 32;
  localparam int unsigned CNT_W = $clog2(DEC_W);

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_ARM  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [DEC_W-1:0] decrement_ns;
    logic [NS_W-1:0]  start_value_ns;
  } req_t;

  typedef struct packed {
    logic            expired;
    logic [NS_W-1:0] remaining_ns;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/interval_timer_decrement_reload.sv
// Top level of the interval timer: request/response handshakes, the reload
// register and a sequencer around one shared subtractor. Uses ivt_pkg.
`default_nettype none

// Channel   | Signals                            | Direction
// ----------+------------------------------------+----------
// request   | req_valid, req_ready, req (req_t)  | in
// response  | rsp_valid, rsp_ready, rsp (rsp_t)  | out
// config    | cfg_we, cfg_wdata                  | in
//
// An arm request, a tick on a disabled timer and a tick that leaves the
// timer positive finish in the cycle they are accepted. A tick that expires
// a one-shot timer passes through compare, overrun and clear; one that
// expires a periodic timer passes through compare, overrun, 32 remainder
// steps and reload, all on the single 58-bit subtractor. Reset clears the
// timer and the reload interval. A waiting response does not block the next
// request as long as the response register is taken in the same cycle.

module interval_timer_decrement_reload
  import ivt_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output      logic            req_ready,
  input  wire req_t            req,
  output      logic            rsp_valid,
  input  wire logic            rsp_ready,
  output      rsp_t            rsp,
  input  wire logic            cfg_we,
  input  wire logic [NS_W-1:0] cfg_wdata
);

  // Sequencer states. IDLE takes requests; OVER forms the overrun past
  // zero; MOD reduces the overrun modulo the interval one bit a cycle;
  // FIN turns the remainder into the reloaded value.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_OVER = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]       state;
  logic [NS_W-1:0]  interval;
  logic [NS_W-1:0]  remaining;
  logic [DEC_W-1:0] dec_hold;
  logic [DEC_W-1:0] over;
  logic [NS_W-1:0]  part;
  logic [CNT_W-1:0] cnt;

  // The shared unit: one subtractor whose borrow doubles as the compare.
  logic [NS_W:0]   sub_a;
  logic [NS_W:0]   sub_b;
  logic [NS_W+1:0] sub_diff;
  logic            sub_borrow;

  logic out_free;
  logic accept;
  logic rem_gt_dec;
  logic rsp_set;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE) && out_free;
  assign accept    = req_valid && req_ready;

  // Operand selection follows the sequencer state.
  always_comb begin
    unique case (state)
      ST_IDLE: begin
        sub_a = {1'b0, remaining};
        sub_b = {{(NS_W+1-DEC_W){1'b0}}, req.decrement_ns};
      end
      ST_OVER: begin
        sub_a = {{(NS_W+1-DEC_W){1'b0}}, dec_hold};
        sub_b = {1'b0, remaining};
      end
      ST_MOD: begin
        // Restoring remainder step: shift in the next overrun bit.
        sub_a = {part, over[DEC_W-1]};
        sub_b = {1'b0, interval};
      end
      default: begin
        sub_a = {1'b0, interval};
        sub_b = {1'b0, part};
      end
    endcase
  end

  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[NS_W+1];
  assign rem_gt_dec = !sub_borrow && (sub_diff[NS_W:0] != '0);

  // A response is loaded when a request finishes in its accept cycle or
  // when the sequencer leaves FIN.
  assign rsp_set = (accept && (req.req_type == REQ_ARM || remaining == '0 || rem_gt_dec))
                   || (state == ST_FIN && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= '0;
    end else if (cfg_we) begin
      interval <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      remaining <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_set) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            priority if (req.req_type == REQ_ARM) begin
              remaining        <= req.start_value_ns;
              rsp.expired      <= 1'b0;
              rsp.remaining_ns <= req.start_value_ns;
            end else if (remaining == '0) begin
              rsp.expired      <= 1'b0;
              rsp.remaining_ns <= '0;
            end else if (rem_gt_dec) begin
              remaining        <= sub_diff[NS_W-1:0];
              rsp.expired      <= 1'b0;
              rsp.remaining_ns <= sub_diff[NS_W-1:0];
            end else begin
              dec_hold <= req.decrement_ns;
              state    <= ST_OVER;
            end
          end
        end
        ST_OVER: begin
          // The overrun fits in the decrement width since remaining >= 1.
          over <= sub_diff[DEC_W-1:0];
          part <= '0;
          cnt  <= CNT_W'(DEC_W - 1);
          // A one-shot timer skips the reduction; FIN then yields zero.
          state <= (interval == '0) ? ST_FIN : ST_MOD;
        end
        ST_MOD: begin
          part <= sub_borrow ? sub_a[NS_W-1:0] : sub_diff[NS_W-1:0];
          over <= {over[DEC_W-2:0], 1'b0};
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_FIN;
          end
        end
        default: begin
          if (out_free) begin
            remaining        <= sub_diff[NS_W-1:0];
            rsp.expired      <= 1'b1;
            rsp.remaining_ns <= sub_diff[NS_W-1:0];
            state            <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // The partial remainder always stays below the interval.
  a_part_below_interval: assert property (
    @(posedge clk) disable iff (rst) (state == ST_MOD) |-> (part < interval)
  ) else $error("partial remainder reached the interval");

  // An arm request answers in the next cycle with the loaded value.
  a_arm_response: assert property (
    @(posedge clk) disable iff (rst)
      (accept && req.req_type == REQ_ARM) |=>
      (rsp_valid && !rsp.expired && rsp.remaining_ns == $past(req.start_value_ns))
  ) else $error("arm request did not load the timer");

  // A periodic reload never leaves the timer disabled.
  a_reload_positive: assert property (
    @(posedge clk) disable iff (rst)
      (state == ST_FIN && out_free && interval != '0) |=> (remaining != '0)
  ) else $error("periodic reload produced zero");

  // The sequencer holds off new requests while it is busy.
  a_busy_blocks: assert property (
    @(posedge clk) disable iff (rst)
      (state == ST_OVER || state == ST_MOD) |=> !$past(req_ready)
  ) else $error("request taken while busy");

endmodule

`default_nettype wire
